[rtl/cis_pkg.sv]
// Package for the contact impulse solver: sizes, codes, body record and
// saturating Q16.16 helpers. No dependencies.
`default_nettype none

package cis_pkg;

  localparam int BODY_COUNT = 64;
  localparam int BODY_IDX_W = $clog2(BODY_COUNT);
  localparam int FRAC_BITS  = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int DIV_STEPS  = 2 * FRAC_BITS + 1;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'h7FFF_FFFF;
  localparam q_t Q_MIN = 32'h8000_0000;
  localparam logic [17:0] Q_ONE = 18'(1) << FRAC_BITS;

  // Transaction kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_CONTACT = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RESTITUTION = 3'd0;
  localparam logic [2:0] REG_FRICTION    = 3'd1;
  localparam logic [2:0] REG_BIAS_GAIN   = 3'd2;
  localparam logic [2:0] REG_SLOP        = 3'd3;
  localparam logic [2:0] REG_INV_DT      = 3'd4;

  localparam logic [16:0] RST_RESTITUTION = 17'd0;
  localparam logic [16:0] RST_FRICTION    = 17'd13107;
  localparam logic [16:0] RST_BIAS_GAIN   = 17'd13107;
  localparam logic [16:0] RST_SLOP        = 17'd655;
  localparam logic [30:0] RST_INV_DT      = 31'd3932160;

  typedef struct packed {
    q_t          vx;
    q_t          vy;
    q_t          w;
    logic [30:0] m;
    logic [30:0] i;
  } body_t;

  function automatic q_t sat33(input logic [32:0] s);
    if (s[32] == s[31]) return s[31:0];
    return s[32] ? Q_MIN : Q_MAX;
  endfunction

  function automatic q_t sadd(input q_t a, input q_t b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic q_t ssub(input q_t a, input q_t b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  function automatic q_t satneg(input q_t a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  function automatic logic signed [32:0] sx33(input q_t a);
    return {a[31], a};
  endfunction

  function automatic logic signed [32:0] ux33(input logic [30:0] a);
    return {2'b00, a};
  endfunction

  // Floored fixed-point product, saturated to 32 bits
  function automatic q_t mulq(input logic signed [32:0] a, input logic signed [32:0] b);
    logic signed [65:0] p;
    logic signed [65:0] q;
    p = a * b;
    q = p >>> FRAC_BITS;
    if ((q[65:31] == '0) || (q[65:31] == '1)) return q[31:0];
    return q[65] ? Q_MIN : Q_MAX;
  endfunction

endpackage

`default_nettype wire

[rtl/cis_in_if.sv]
// Input channel of the contact impulse solver: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface cis_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         body_a;
  logic [5:0]         body_b;
  logic signed [31:0] arm_a_x;
  logic signed [31:0] arm_a_y;
  logic signed [31:0] arm_b_x;
  logic signed [31:0] arm_b_y;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [31:0] separation;
  logic [30:0]        load_inv_mass;
  logic [30:0]        load_inv_inertia;

  modport source (
    output valid, kind, body_a, body_b, arm_a_x, arm_a_y, arm_b_x, arm_b_y,
           normal_x, normal_y, separation, load_inv_mass, load_inv_inertia,
    input  ready
  );
  modport sink (
    input  valid, kind, body_a, body_b, arm_a_x, arm_a_y, arm_b_x, arm_b_y,
           normal_x, normal_y, separation, load_inv_mass, load_inv_inertia,
    output ready
  );
endinterface

`default_nettype wire

[rtl/cis_out_if.sv]
// Result channel of the contact impulse solver: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface cis_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_vel_x;
  logic signed [31:0] a_vel_y;
  logic signed [31:0] a_spin;
  logic signed [31:0] b_vel_x;
  logic signed [31:0] b_vel_y;
  logic signed [31:0] b_spin;
  logic [30:0]        normal_impulse;
  logic signed [31:0] tangent_impulse;

  modport source (
    output valid, a_vel_x, a_vel_y, a_spin, b_vel_x, b_vel_y, b_spin,
           normal_impulse, tangent_impulse,
    input  ready
  );
  modport sink (
    input  valid, a_vel_x, a_vel_y, a_spin, b_vel_x, b_vel_y, b_spin,
           normal_impulse, tangent_impulse,
    output ready
  );
endinterface

`default_nettype wire

[rtl/contact_impulse_solver.sv]
// Contact impulse solver top level: body memory, sequencer, shared multiplier
// and reciprocal divider. Depends on cis_pkg, cis_in_if and cis_out_if.
`default_nettype none

// One transaction at a time. A body load writes the memory on acceptance and
// goes straight to the output load, a two-body read through a fetch, and a
// contact through a fetch from the body memory, two effective-mass passes of
// 16 steps each, each followed by a restoring reciprocal (one quotient bit per
// cycle), the bias (2 steps), the normal and friction passes (23 steps each,
// at most one multiply per step on the single shared multiplier), the write-back
// of a then b, and the output load. Contacts between two static bodies finish
// after the fetch, like a read. The result sits in an output register, so
// the next transaction is taken while a result still waits; a second result
// that cannot leave holds the sequencer and with it the input. Configuration
// registers are written whenever the port asks, so write them only while
// nothing is in flight. The body memory needs no clearing, and reading a
// never-loaded body gives garbage.

module contact_impulse_solver import cis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cis_in_if.sink                in_chan,
  cis_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [48:0] {
    S_IDLE  = 49'd1 << 0,  S_FETCH = 49'd1 << 1,  S_DIV   = 49'd1 << 2,
    S_WB_A  = 49'd1 << 3,  S_WB_B  = 49'd1 << 4,  S_DONE  = 49'd1 << 5,
    S_E0    = 49'd1 << 6,  S_E1    = 49'd1 << 7,  S_E2    = 49'd1 << 8,
    S_E3    = 49'd1 << 9,  S_E4    = 49'd1 << 10, S_E5    = 49'd1 << 11,
    S_E6    = 49'd1 << 12, S_E7    = 49'd1 << 13, S_E8    = 49'd1 << 14,
    S_E9    = 49'd1 << 15, S_E10   = 49'd1 << 16, S_E11   = 49'd1 << 17,
    S_E12   = 49'd1 << 18, S_E13   = 49'd1 << 19, S_E14   = 49'd1 << 20,
    S_E15   = 49'd1 << 21, S_B0    = 49'd1 << 22, S_B1    = 49'd1 << 23,
    S_R0    = 49'd1 << 24, S_R1    = 49'd1 << 25, S_R2    = 49'd1 << 26,
    S_R3    = 49'd1 << 27, S_R4    = 49'd1 << 28, S_R5    = 49'd1 << 29,
    S_R6    = 49'd1 << 30, S_N0    = 49'd1 << 31, S_N1    = 49'd1 << 32,
    S_T0    = 49'd1 << 33, S_T1    = 49'd1 << 34, S_P0    = 49'd1 << 35,
    S_P1    = 49'd1 << 36, S_P2    = 49'd1 << 37, S_P3    = 49'd1 << 38,
    S_P4    = 49'd1 << 39, S_P5    = 49'd1 << 40, S_P6    = 49'd1 << 41,
    S_P7    = 49'd1 << 42, S_P8    = 49'd1 << 43, S_P9    = 49'd1 << 44,
    S_P10   = 49'd1 << 45, S_P11   = 49'd1 << 46, S_P12   = 49'd1 << 47,
    S_P13   = 49'd1 << 48
  } state_t;

  // ---------------------------------------------------------------- config
  logic [16:0] rest_r, fric_r, gain_r, slop_r;
  logic [30:0] inv_dt_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r   <= RST_RESTITUTION;
      fric_r   <= RST_FRICTION;
      gain_r   <= RST_BIAS_GAIN;
      slop_r   <= RST_SLOP;
      inv_dt_r <= RST_INV_DT;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_RESTITUTION: rest_r   <= pwdata[16:0];
        REG_FRICTION:    fric_r   <= pwdata[16:0];
        REG_BIAS_GAIN:   gain_r   <= pwdata[16:0];
        REG_SLOP:        slop_r   <= pwdata[16:0];
        REG_INV_DT:      inv_dt_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_RESTITUTION: prdata = {15'd0, rest_r};
      REG_FRICTION:    prdata = {15'd0, fric_r};
      REG_BIAS_GAIN:   prdata = {15'd0, gain_r};
      REG_SLOP:        prdata = {15'd0, slop_r};
      REG_INV_DT:      prdata = {1'b0, inv_dt_r};
      default:         prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- body memory
  body_t                 mem_r [BODY_COUNT];
  body_t                 rd_a_r, rd_b_r;
  logic                  mem_we;
  logic [BODY_IDX_W-1:0] mem_waddr;
  body_t                 mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    rd_a_r <= mem_r[in_chan.body_a[BODY_IDX_W-1:0]];
    rd_b_r <= mem_r[in_chan.body_b[BODY_IDX_W-1:0]];
  end

  // --------------------------------------------------------- working state
  state_t                state_r, state_nxt;
  logic                  pass_r, pass_nxt;          // 0: normal, 1: tangent
  logic [1:0]            kind_r, kind_nxt;
  logic [BODY_IDX_W-1:0] idx_a_r, idx_a_nxt, idx_b_r, idx_b_nxt;
  q_t                    r1x_r, r1x_nxt, r1y_r, r1y_nxt, r2x_r, r2x_nxt, r2y_r, r2y_nxt;
  logic signed [17:0]    nx_r, nx_nxt, ny_r, ny_nxt;
  q_t                    sep_r, sep_nxt;
  q_t                    avx_r, avx_nxt, avy_r, avy_nxt, aw_r, aw_nxt;
  q_t                    bvx_r, bvx_nxt, bvy_r, bvy_nxt, bw_r, bw_nxt;
  logic [30:0]           am_r, am_nxt, ai_r, ai_nxt, bm_r, bm_nxt, bi_r, bi_nxt;
  q_t                    acc_r, acc_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  q_t                    mn_r, mn_nxt, mt_r, mt_nxt, bias_r, bias_nxt;
  q_t                    dpn_r, dpn_nxt, dpt_r, dpt_nxt, px_r, px_nxt, py_r, py_nxt;
  q_t                    div_k_r, div_k_nxt;
  logic [32:0]           div_rem_r, div_rem_nxt, div_q_r, div_q_nxt;
  logic [5:0]            div_cnt_r, div_cnt_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  q_t                    o_avx_r, o_avy_r, o_aw_r, o_bvx_r, o_bvy_r, o_bw_r, o_dpt_r;
  logic [30:0]           o_dpn_r;
  logic                  out_load;

  // ------------------------------------------------------ shared operands
  logic                  same;
  q_t                    nx32, ny32, tx32, dx, dy, imp, pen_s, pen, m, recip;
  logic signed [32:0]    mx, my;
  logic [32:0]           rem_sh, q_fin;
  logic                  ge;
  logic [17:0]           one_plus_rest;

  assign same          = (idx_a_r == idx_b_r);
  assign nx32          = 32'(nx_r);
  assign ny32          = 32'(ny_r);
  assign tx32          = satneg(ny32);
  assign dx            = pass_r ? tx32 : nx32;
  assign dy            = pass_r ? nx32 : ny32;
  assign imp           = pass_r ? dpt_r : dpn_r;
  assign pen_s         = sadd(sep_r, {15'd0, slop_r});
  assign pen           = pen_s[31] ? pen_s : '0;
  assign one_plus_rest = Q_ONE + {1'b0, rest_r};
  assign m             = mulq(mx, my);

  // Restoring reciprocal of 2^(2*FRAC_BITS): the dividend is a single one bit
  assign rem_sh = {div_rem_r[31:0], (div_cnt_r == 6'(DIV_STEPS))};
  assign ge     = (rem_sh >= {1'b0, div_k_r});
  assign q_fin  = {div_q_r[31:0], ge};
  assign recip  = (div_k_r[31] || (div_k_r == '0)) ? '0 :
                  ((q_fin[32] || q_fin[31]) ? Q_MAX : q_fin[31:0]);

  // Multiplier operand select: one product per step
  always_comb begin
    mx = '0;
    my = '0;
    unique case (state_r)
      S_E0:  begin mx = sx33(r1x_r);  my = sx33(dx);     end
      S_E1:  begin mx = sx33(r1y_r);  my = sx33(dy);     end
      S_E2:  begin mx = sx33(acc_r);  my = sx33(acc_r);  end
      S_E3:  begin mx = sx33(r1x_r);  my = sx33(r1x_r);  end
      S_E4:  begin mx = sx33(r1y_r);  my = sx33(r1y_r);  end
      S_E6:  begin mx = ux33(ai_r);   my = sx33(acc_r);  end
      S_E7:  begin mx = sx33(r2x_r);  my = sx33(dx);     end
      S_E8:  begin mx = sx33(r2y_r);  my = sx33(dy);     end
      S_E9:  begin mx = sx33(acc_r);  my = sx33(acc_r);  end
      S_E10: begin mx = sx33(r2x_r);  my = sx33(r2x_r);  end
      S_E11: begin mx = sx33(r2y_r);  my = sx33(r2y_r);  end
      S_E13: begin mx = ux33(bi_r);   my = sx33(acc_r);  end
      S_B0:  begin mx = {16'd0, gain_r}; my = {2'b00, inv_dt_r}; end
      S_B1:  begin mx = sx33(t1_r);   my = sx33(pen);    end
      S_R0:  begin mx = sx33(bw_r);   my = sx33(r2y_r);  end
      S_R1:  begin mx = sx33(bw_r);   my = sx33(r2x_r);  end
      S_R3:  begin mx = sx33(aw_r);   my = sx33(r1y_r);  end
      S_R4:  begin mx = sx33(aw_r);   my = sx33(r1x_r);  end
      S_R5:  begin mx = sx33(acc_r);  my = sx33(dx);     end
      S_R6:  begin mx = sx33(t1_r);   my = sx33(dy);     end
      S_N0:  begin mx = sx33(acc_r);  my = {15'd0, one_plus_rest}; end
      S_N1:  begin mx = sx33(mn_r);   my = sx33(t1_r);   end
      S_T0:  begin mx = sx33(mt_r);   my = sx33(satneg(acc_r)); end
      S_T1:  begin mx = {16'd0, fric_r}; my = sx33(dpn_r); end
      S_P0:  begin mx = sx33(imp);    my = sx33(dx);     end
      S_P1:  begin mx = sx33(imp);    my = sx33(dy);     end
      S_P2:  begin mx = ux33(am_r);   my = sx33(px_r);   end
      S_P3:  begin mx = ux33(am_r);   my = sx33(py_r);   end
      S_P4:  begin mx = sx33(r1x_r);  my = sx33(py_r);   end
      S_P5:  begin mx = sx33(r1y_r);  my = sx33(px_r);   end
      S_P6:  begin mx = ux33(ai_r);   my = sx33(acc_r);  end
      S_P8:  begin mx = ux33(bm_r);   my = sx33(px_r);   end
      S_P9:  begin mx = ux33(bm_r);   my = sx33(py_r);   end
      S_P10: begin mx = sx33(r2x_r);  my = sx33(py_r);   end
      S_P11: begin mx = sx33(r2y_r);  my = sx33(px_r);   end
      S_P12: begin mx = ux33(bi_r);   my = sx33(acc_r);  end
      default: ;
    endcase
  end

  // Sequencer and datapath updates
  always_comb begin
    state_nxt = state_r;   pass_nxt = pass_r;     kind_nxt = kind_r;
    idx_a_nxt = idx_a_r;   idx_b_nxt = idx_b_r;
    r1x_nxt = r1x_r; r1y_nxt = r1y_r; r2x_nxt = r2x_r; r2y_nxt = r2y_r;
    nx_nxt = nx_r;   ny_nxt = ny_r;   sep_nxt = sep_r;
    avx_nxt = avx_r; avy_nxt = avy_r; aw_nxt = aw_r; am_nxt = am_r; ai_nxt = ai_r;
    bvx_nxt = bvx_r; bvy_nxt = bvy_r; bw_nxt = bw_r; bm_nxt = bm_r; bi_nxt = bi_r;
    acc_nxt = acc_r; t1_nxt = t1_r;   t2_nxt = t2_r;
    mn_nxt = mn_r;   mt_nxt = mt_r;   bias_nxt = bias_r;
    dpn_nxt = dpn_r; dpt_nxt = dpt_r; px_nxt = px_r; py_nxt = py_r;
    div_k_nxt = div_k_r; div_rem_nxt = div_rem_r; div_q_nxt = div_q_r;
    div_cnt_nxt = div_cnt_r;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_a_r;
    mem_wdata = '{vx: avx_r, vy: avy_r, w: aw_r, m: am_r, i: ai_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt  = in_chan.kind;
          idx_a_nxt = in_chan.body_a[BODY_IDX_W-1:0];
          idx_b_nxt = in_chan.body_b[BODY_IDX_W-1:0];
          r1x_nxt = in_chan.arm_a_x;  r1y_nxt = in_chan.arm_a_y;
          r2x_nxt = in_chan.arm_b_x;  r2y_nxt = in_chan.arm_b_y;
          nx_nxt  = in_chan.normal_x; ny_nxt  = in_chan.normal_y;
          sep_nxt = in_chan.separation;
          pass_nxt = 1'b0;
          dpn_nxt  = '0;
          dpt_nxt  = '0;
          unique case (in_chan.kind) inside
            KIND_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = in_chan.body_a[BODY_IDX_W-1:0];
              mem_wdata = '{vx: in_chan.arm_a_x, vy: in_chan.arm_a_y,
                            w: in_chan.arm_b_x, m: in_chan.load_inv_mass,
                            i: in_chan.load_inv_inertia};
              avx_nxt = in_chan.arm_a_x;
              avy_nxt = in_chan.arm_a_y;
              aw_nxt  = in_chan.arm_b_x;
              bvx_nxt = '0; bvy_nxt = '0; bw_nxt = '0;
              state_nxt = S_DONE;
            end
            KIND_CONTACT, KIND_READ: state_nxt = S_FETCH;
            default: ;  // unused kind: dropped
          endcase
        end
      end
      S_FETCH: begin
        avx_nxt = rd_a_r.vx; avy_nxt = rd_a_r.vy; aw_nxt = rd_a_r.w;
        am_nxt  = rd_a_r.m;  ai_nxt  = rd_a_r.i;
        bvx_nxt = rd_b_r.vx; bvy_nxt = rd_b_r.vy; bw_nxt = rd_b_r.w;
        bm_nxt  = rd_b_r.m;  bi_nxt  = rd_b_r.i;
        // two static bodies: contact skipped
        if (kind_r == KIND_CONTACT && !(rd_a_r.m == '0 && rd_b_r.m == '0))
          state_nxt = S_E0;
        else
          state_nxt = S_DONE;
      end
      // effective mass along (dx, dy)
      S_E0:  begin acc_nxt = m;                 state_nxt = S_E1;  end
      S_E1:  begin acc_nxt = sadd(acc_r, m);    state_nxt = S_E2;  end
      S_E2:  begin t1_nxt  = m;                 state_nxt = S_E3;  end
      S_E3:  begin acc_nxt = m;                 state_nxt = S_E4;  end
      S_E4:  begin acc_nxt = sadd(acc_r, m);    state_nxt = S_E5;  end
      S_E5:  begin acc_nxt = ssub(acc_r, t1_r); state_nxt = S_E6;  end
      S_E6:  begin t2_nxt  = m;                 state_nxt = S_E7;  end
      S_E7:  begin acc_nxt = m;                 state_nxt = S_E8;  end
      S_E8:  begin acc_nxt = sadd(acc_r, m);    state_nxt = S_E9;  end
      S_E9:  begin t1_nxt  = m;                 state_nxt = S_E10; end
      S_E10: begin acc_nxt = m;                 state_nxt = S_E11; end
      S_E11: begin acc_nxt = sadd(acc_r, m);    state_nxt = S_E12; end
      S_E12: begin acc_nxt = ssub(acc_r, t1_r); state_nxt = S_E13; end
      S_E13: begin t1_nxt  = m;                 state_nxt = S_E14; end
      S_E14: begin t1_nxt  = sadd(t2_r, t1_r);  state_nxt = S_E15; end
      S_E15: begin
        div_k_nxt   = sadd(sadd({1'b0, am_r}, {1'b0, bm_r}), t1_r);
        div_rem_nxt = '0;
        div_q_nxt   = '0;
        div_cnt_nxt = 6'(DIV_STEPS);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        div_rem_nxt = ge ? (rem_sh - {1'b0, div_k_r}) : rem_sh;
        div_q_nxt   = q_fin;
        div_cnt_nxt = div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) begin
          if (!pass_r) begin
            mn_nxt    = recip;
            pass_nxt  = 1'b1;
            state_nxt = S_E0;
          end else begin
            mt_nxt    = recip;
            pass_nxt  = 1'b0;
            state_nxt = S_B0;
          end
        end
      end
      // position bias
      S_B0: begin t1_nxt   = m;         state_nxt = S_B1; end
      S_B1: begin bias_nxt = satneg(m); state_nxt = S_R0; end
      // relative velocity along (dx, dy)
      S_R0: begin acc_nxt = sadd(bvx_r, satneg(m)); state_nxt = S_R1; end
      S_R1: begin t1_nxt  = sadd(bvy_r, m);         state_nxt = S_R2; end
      S_R2: begin
        acc_nxt   = ssub(acc_r, avx_r);
        t1_nxt    = ssub(t1_r, avy_r);
        state_nxt = S_R3;
      end
      S_R3: begin acc_nxt = ssub(acc_r, satneg(m)); state_nxt = S_R4; end
      S_R4: begin t1_nxt  = ssub(t1_r, m);          state_nxt = S_R5; end
      S_R5: begin t2_nxt  = m;                      state_nxt = S_R6; end
      S_R6: begin
        acc_nxt   = sadd(t2_r, m);
        state_nxt = pass_r ? S_T0 : S_N0;
      end
      // normal impulse, clamped at zero
      S_N0: begin t1_nxt  = sadd(satneg(m), bias_r); state_nxt = S_N1; end
      S_N1: begin dpn_nxt = m[31] ? '0 : m;          state_nxt = S_P0; end
      // friction impulse, clamped to the friction cone
      S_T0: begin dpt_nxt = m; state_nxt = S_T1; end
      S_T1: begin
        if (dpt_r > m)       dpt_nxt = m;
        else if (dpt_r < -m) dpt_nxt = -m;
        state_nxt = S_P0;
      end
      // apply impulse: body a then body b
      S_P0:  begin px_nxt  = m;                 state_nxt = S_P1;  end
      S_P1:  begin py_nxt  = m;                 state_nxt = S_P2;  end
      S_P2:  begin avx_nxt = ssub(avx_r, m);    state_nxt = S_P3;  end
      S_P3:  begin avy_nxt = ssub(avy_r, m);    state_nxt = S_P4;  end
      S_P4:  begin t1_nxt  = m;                 state_nxt = S_P5;  end
      S_P5:  begin acc_nxt = ssub(t1_r, m);     state_nxt = S_P6;  end
      S_P6:  begin aw_nxt  = ssub(aw_r, m);     state_nxt = S_P7;  end
      S_P7: begin
        // same body on both sides: b sees the update of a
        if (same) begin
          bvx_nxt = avx_r; bvy_nxt = avy_r; bw_nxt = aw_r;
        end
        state_nxt = S_P8;
      end
      S_P8:  begin bvx_nxt = sadd(bvx_r, m);    state_nxt = S_P9;  end
      S_P9:  begin bvy_nxt = sadd(bvy_r, m);    state_nxt = S_P10; end
      S_P10: begin t1_nxt  = m;                 state_nxt = S_P11; end
      S_P11: begin acc_nxt = ssub(t1_r, m);     state_nxt = S_P12; end
      S_P12: begin bw_nxt  = sadd(bw_r, m);     state_nxt = S_P13; end
      S_P13: begin
        if (same) begin
          avx_nxt = bvx_r; avy_nxt = bvy_r; aw_nxt = bw_r;
        end
        if (pass_r) begin
          state_nxt = S_WB_A;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = S_R0;
        end
      end
      S_WB_A: begin
        mem_we    = 1'b1;
        state_nxt = S_WB_B;
      end
      S_WB_B: begin
        mem_we    = 1'b1;
        mem_waddr = idx_b_r;
        mem_wdata = '{vx: bvx_r, vy: bvy_r, w: bw_r, m: bm_r, i: bi_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (out_load)       out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r  <= pass_nxt;  kind_r  <= kind_nxt;
    idx_a_r <= idx_a_nxt; idx_b_r <= idx_b_nxt;
    r1x_r <= r1x_nxt; r1y_r <= r1y_nxt; r2x_r <= r2x_nxt; r2y_r <= r2y_nxt;
    nx_r  <= nx_nxt;  ny_r  <= ny_nxt;  sep_r <= sep_nxt;
    avx_r <= avx_nxt; avy_r <= avy_nxt; aw_r <= aw_nxt; am_r <= am_nxt; ai_r <= ai_nxt;
    bvx_r <= bvx_nxt; bvy_r <= bvy_nxt; bw_r <= bw_nxt; bm_r <= bm_nxt; bi_r <= bi_nxt;
    acc_r <= acc_nxt; t1_r  <= t1_nxt;  t2_r  <= t2_nxt;
    mn_r  <= mn_nxt;  mt_r  <= mt_nxt;  bias_r <= bias_nxt;
    dpn_r <= dpn_nxt; dpt_r <= dpt_nxt; px_r <= px_nxt; py_r <= py_nxt;
    div_k_r <= div_k_nxt; div_rem_r <= div_rem_nxt; div_q_r <= div_q_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (out_load) begin
      o_avx_r <= avx_r; o_avy_r <= avy_r; o_aw_r <= aw_r;
      o_bvx_r <= bvx_r; o_bvy_r <= bvy_r; o_bw_r <= bw_r;
      o_dpn_r <= dpn_r[30:0];
      o_dpt_r <= dpt_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.a_vel_x         = o_avx_r;
  assign out_chan.a_vel_y         = o_avy_r;
  assign out_chan.a_spin          = o_aw_r;
  assign out_chan.b_vel_x         = o_bvx_r;
  assign out_chan.b_vel_y         = o_bvy_r;
  assign out_chan.b_spin          = o_bw_r;
  assign out_chan.normal_impulse  = o_dpn_r;
  assign out_chan.tangent_impulse = o_dpt_r;

endmodule

`default_nettype wire
